>>> src/aml_soft_off_type_scanner_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the soft-off sleep-type scanner
// Shorthand for clocked implications with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef AML_SOFT_OFF_TYPE_SCANNER_ASSERT_SVH
`define AML_SOFT_OFF_TYPE_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AOST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AOST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/aost_pkg.sv
// ----------------------------------------------------------------------------
// aost_pkg
// Shared constants and the queue entry type of the soft-off type scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package aost_pkg;

  localparam int PREFIX_LEN      = 6;
  localparam int PIDX_W          = $clog2(PREFIX_LEN);
  localparam int MATCH_MAX_BYTES = 29;
  localparam int SLOTS           = (MATCH_MAX_BYTES + PREFIX_LEN - 1) / PREFIX_LEN + 1;
  localparam int AGE_W           = $clog2(MATCH_MAX_BYTES);
  localparam int CNT_W           = 4;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int TYPE_W          = 7;

  localparam logic [7:0] NAME_OP    = 8'h08;
  localparam logic [7:0] PACKAGE_OP = 8'h12;
  localparam logic [7:0] CHAR_US    = 8'h5F;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_5     = 8'h35;

  localparam logic [7:0] OP_ZERO  = 8'h00;
  localparam logic [7:0] OP_ONE   = 8'h01;
  localparam logic [7:0] OP_BYTE  = 8'h0A;
  localparam logic [7:0] OP_WORD  = 8'h0B;
  localparam logic [7:0] OP_DWORD = 8'h0C;
  localparam logic [7:0] OP_QWORD = 8'h0E;

  // Byte i of the fixed prefix sits at bits [8*i +: 8].
  localparam logic [PREFIX_LEN*8-1:0] PREFIX_BYTES =
    {PACKAGE_OP, CHAR_US, CHAR_5, CHAR_S, CHAR_US, NAME_OP};

  localparam logic [1:0] INT_BAD   = 2'd0;
  localparam logic [1:0] INT_SHORT = 2'd1;
  localparam logic [1:0] INT_LONG  = 2'd2;

  typedef struct packed {
    logic [7:0]            data;
    logic                  last;
    logic [PREFIX_LEN-1:0] prefix_hit;
    logic                  count_ok;
    logic [1:0]            int_class;
    logic [CNT_W-1:0]      int_extra;
  } entry_t;

endpackage

`default_nettype wire

>>> src/aml_soft_off_type_scanner.sv
// ----------------------------------------------------------------------------
// aml_soft_off_type_scanner
// Takes one table body byte per cycle, with no stall of its own, and gives
// one result per table after its final byte is accepted. The rate is set by
// the match unit, which advances every open match attempt by one byte per
// cycle; a four-entry queue lies between the byte decoder and the match
// unit, and the result waits in an output register, so the input stalls
// only when a result is left unread, a further final byte reaches the match
// unit and the queue fills behind it. No start-up clearing pass is needed.
// The user must write the fallback sleep type on the configuration channel
// while no table is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module aml_soft_off_type_scanner (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_last_byte,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic                             out_found,
  output logic [aost_pkg::TYPE_W-1:0]      out_sleep_type_a,
  output logic [aost_pkg::TYPE_W-1:0]      out_sleep_type_b,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [aost_pkg::TYPE_W-1:0] cfg_fallback_sleep_type
);

  localparam logic [aost_pkg::TYPE_W-1:0] FALLBACK_RESET = 7'd5;

  logic [aost_pkg::TYPE_W-1:0] fallback_r;
  aost_pkg::entry_t            wr_entry;
  aost_pkg::entry_t            rd_entry;
  logic                        q_wr_en;
  logic                        q_rd_en;
  logic                        q_full;
  logic                        q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= FALLBACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fallback_r <= cfg_fallback_sleep_type;
    end
  end

  aost_front u_front (
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_wr_en      (q_wr_en),
    .q_entry      (wr_entry)
  );

  aost_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_entry (wr_entry),
    .full     (q_full),
    .rd_en    (q_rd_en),
    .rd_entry (rd_entry),
    .empty    (q_empty)
  );

  aost_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_entry          (rd_entry),
    .q_rd_en          (q_rd_en),
    .fallback         (fallback_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_found        (out_found),
    .out_sleep_type_a (out_sleep_type_a),
    .out_sleep_type_b (out_sleep_type_b)
  );

endmodule

`default_nettype wire

>>> src/aost_queue.sv
// ----------------------------------------------------------------------------
// aost_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module aost_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire aost_pkg::entry_t wr_entry,
  output logic                 full,
  input  wire logic            rd_en,
  output aost_pkg::entry_t     rd_entry,
  output logic                 empty
);

  aost_pkg::entry_t                mem_r [aost_pkg::QUEUE_DEPTH];
  logic [aost_pkg::QUEUE_AW:0]     wr_ptr_r;
  logic [aost_pkg::QUEUE_AW:0]     rd_ptr_r;

  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign full     = (wr_ptr_r[aost_pkg::QUEUE_AW] != rd_ptr_r[aost_pkg::QUEUE_AW]) &&
                    (wr_ptr_r[aost_pkg::QUEUE_AW-1:0] == rd_ptr_r[aost_pkg::QUEUE_AW-1:0]);
  assign rd_entry = mem_r[rd_ptr_r[aost_pkg::QUEUE_AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r[aost_pkg::QUEUE_AW-1:0]] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

>>> src/aost_front.sv
// ----------------------------------------------------------------------------
// aost_front
// Accepts table bytes and decodes the properties the matcher needs per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module aost_front (
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        q_full,
  output logic             q_wr_en,
  output aost_pkg::entry_t q_entry
);

  localparam logic [7:0] MIN_COUNT = 8'd2;

  assign in_full = q_full;
  assign q_wr_en = in_push && !q_full;

  always_comb begin
    q_entry          = '0;
    q_entry.data     = in_data_byte;
    q_entry.last     = in_last_byte;
    q_entry.count_ok = (in_data_byte >= MIN_COUNT);
    for (int i = 0; i < aost_pkg::PREFIX_LEN; i++) begin
      q_entry.prefix_hit[i] = (in_data_byte == aost_pkg::PREFIX_BYTES[8*i +: 8]);
    end
    unique case (in_data_byte) inside
      aost_pkg::OP_ZERO, aost_pkg::OP_ONE: begin
        q_entry.int_class = aost_pkg::INT_SHORT;
        q_entry.int_extra = '0;
      end
      aost_pkg::OP_BYTE: begin
        q_entry.int_class = aost_pkg::INT_LONG;
        q_entry.int_extra = aost_pkg::CNT_W'(1);
      end
      aost_pkg::OP_WORD: begin
        q_entry.int_class = aost_pkg::INT_LONG;
        q_entry.int_extra = aost_pkg::CNT_W'(2);
      end
      aost_pkg::OP_DWORD: begin
        q_entry.int_class = aost_pkg::INT_LONG;
        q_entry.int_extra = aost_pkg::CNT_W'(4);
      end
      aost_pkg::OP_QWORD: begin
        q_entry.int_class = aost_pkg::INT_LONG;
        q_entry.int_extra = aost_pkg::CNT_W'(8);
      end
      default: begin
        q_entry.int_class = aost_pkg::INT_BAD;
        q_entry.int_extra = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/aost_back.sv
// ----------------------------------------------------------------------------
// aost_back
// Runs the concurrent match attempts, keeps the earliest match and holds the
// result of each table in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aost_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire aost_pkg::entry_t              q_entry,
  output logic                               q_rd_en,
  input  wire logic [aost_pkg::TYPE_W-1:0]   fallback,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_found,
  output logic [aost_pkg::TYPE_W-1:0]        out_sleep_type_a,
  output logic [aost_pkg::TYPE_W-1:0]        out_sleep_type_b
);

  localparam logic [2:0] PH_NAME    = 3'd0;
  localparam logic [2:0] PH_LEAD    = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_COUNT   = 3'd3;
  localparam logic [2:0] PH_INTOP   = 3'd4;
  localparam logic [2:0] PH_INTPAY  = 3'd5;
  localparam logic [2:0] PH_INTSKIP = 3'd6;

  localparam int S  = aost_pkg::SLOTS;
  localparam int AW = aost_pkg::AGE_W;
  localparam int CW = aost_pkg::CNT_W;
  localparam int TW = aost_pkg::TYPE_W;

  logic [S-1:0]  live_r, live_nxt;
  logic [2:0]    phase_r  [S];
  logic [2:0]    phase_nxt[S];
  logic [CW-1:0] cnt_r    [S];
  logic [CW-1:0] cnt_nxt  [S];
  logic [AW-1:0] age_r    [S];
  logic [AW-1:0] age_nxt  [S];
  logic [S-1:0]  second_r, second_nxt;
  logic [TW-1:0] cur_r    [S];
  logic [TW-1:0] cur_nxt  [S];
  logic [TW-1:0] val_a_r  [S];
  logic [TW-1:0] val_a_nxt[S];

  logic          lat_r, lat_nxt;
  logic [AW-1:0] lat_age_r, lat_age_nxt;
  logic [TW-1:0] lat_a_r, lat_a_nxt;
  logic [TW-1:0] lat_b_r, lat_b_nxt;

  logic          out_valid_r;
  logic          out_found_r;
  logic [TW-1:0] out_a_r;
  logic [TW-1:0] out_b_r;

  logic          step;

  assign out_empty        = !out_valid_r;
  assign out_found        = out_found_r;
  assign out_sleep_type_a = out_a_r;
  assign out_sleep_type_b = out_b_r;

  assign step    = !q_empty && (!q_entry.last || !out_valid_r || out_pop);
  assign q_rd_en = step;

  always_comb begin
    logic          fin;
    logic [TW-1:0] fin_val;
    logic          taken;
    logic          win;
    logic [AW-1:0] win_age;
    logic [TW-1:0] win_a;
    logic [TW-1:0] win_b;
    logic [AW-1:0] lat_age_now;

    live_nxt    = live_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    age_nxt     = age_r;
    second_nxt  = second_r;
    cur_nxt     = cur_r;
    val_a_nxt   = val_a_r;
    fin         = 1'b0;
    fin_val     = '0;
    taken       = 1'b0;
    win         = 1'b0;
    win_age     = '0;
    win_a       = '0;
    win_b       = '0;
    lat_age_now = (lat_age_r == '1) ? lat_age_r : lat_age_r + 1'b1;

    for (int s = 0; s < S; s++) begin
      fin     = 1'b0;
      fin_val = '0;
      if (live_r[s]) begin
        age_nxt[s] = age_r[s] + 1'b1;
        unique case (phase_r[s])
          PH_NAME: begin
            if (!q_entry.prefix_hit[cnt_r[s][aost_pkg::PIDX_W-1:0]]) begin
              live_nxt[s] = 1'b0;
            end else if (cnt_r[s] == CW'(aost_pkg::PREFIX_LEN - 1)) begin
              phase_nxt[s] = PH_LEAD;
            end else begin
              cnt_nxt[s] = cnt_r[s] + 1'b1;
            end
          end
          PH_LEAD: begin
            if (q_entry.data[7:6] == 2'b00) begin
              phase_nxt[s] = PH_COUNT;
            end else begin
              phase_nxt[s] = PH_EXT;
              cnt_nxt[s]   = {{(CW-2){1'b0}}, q_entry.data[7:6]};
            end
          end
          PH_EXT: begin
            if (cnt_r[s] == CW'(1)) begin
              phase_nxt[s] = PH_COUNT;
            end else begin
              cnt_nxt[s] = cnt_r[s] - 1'b1;
            end
          end
          PH_COUNT: begin
            if (q_entry.count_ok) begin
              phase_nxt[s]  = PH_INTOP;
              second_nxt[s] = 1'b0;
            end else begin
              live_nxt[s] = 1'b0;
            end
          end
          PH_INTOP: begin
            if (q_entry.int_class == aost_pkg::INT_SHORT) begin
              fin     = 1'b1;
              fin_val = {{(TW-1){1'b0}}, q_entry.data[0]};
            end else if (q_entry.int_class == aost_pkg::INT_LONG) begin
              phase_nxt[s] = PH_INTPAY;
              cnt_nxt[s]   = q_entry.int_extra;
            end else begin
              live_nxt[s] = 1'b0;
            end
          end
          PH_INTPAY: begin
            cur_nxt[s] = q_entry.data[TW-1:0];
            if (cnt_r[s] == CW'(1)) begin
              fin     = 1'b1;
              fin_val = q_entry.data[TW-1:0];
            end else begin
              phase_nxt[s] = PH_INTSKIP;
              cnt_nxt[s]   = cnt_r[s] - 1'b1;
            end
          end
          PH_INTSKIP: begin
            if (cnt_r[s] == CW'(1)) begin
              fin     = 1'b1;
              fin_val = cur_r[s];
            end else begin
              cnt_nxt[s] = cnt_r[s] - 1'b1;
            end
          end
          default: begin
            live_nxt[s] = 1'b0;
          end
        endcase
        if (fin) begin
          if (!second_r[s]) begin
            val_a_nxt[s]  = fin_val;
            second_nxt[s] = 1'b1;
            phase_nxt[s]  = PH_INTOP;
          end else begin
            live_nxt[s] = 1'b0;
            if (!win || age_nxt[s] > win_age) begin
              win     = 1'b1;
              win_age = age_nxt[s];
              win_a   = val_a_r[s];
              win_b   = fin_val;
            end
          end
        end
      end
    end

    if (q_entry.prefix_hit[0] && !q_entry.last) begin
      for (int s = 0; s < S; s++) begin
        if (!live_r[s] && !taken) begin
          taken         = 1'b1;
          live_nxt[s]   = 1'b1;
          phase_nxt[s]  = PH_NAME;
          cnt_nxt[s]    = CW'(1);
          age_nxt[s]    = '0;
          second_nxt[s] = 1'b0;
        end
      end
    end

    lat_nxt     = lat_r;
    lat_age_nxt = lat_age_now;
    lat_a_nxt   = lat_a_r;
    lat_b_nxt   = lat_b_r;
    if (win && (!lat_r || win_age > lat_age_now)) begin
      lat_nxt     = 1'b1;
      lat_age_nxt = win_age;
      lat_a_nxt   = win_a;
      lat_b_nxt   = win_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      lat_r  <= 1'b0;
    end else if (step) begin
      live_r <= q_entry.last ? '0 : live_nxt;
      lat_r  <= q_entry.last ? 1'b0 : lat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      age_r     <= age_nxt;
      second_r  <= second_nxt;
      cur_r     <= cur_nxt;
      val_a_r   <= val_a_nxt;
      lat_age_r <= lat_age_nxt;
      lat_a_r   <= lat_a_nxt;
      lat_b_r   <= lat_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && q_entry.last) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && q_entry.last) begin
      out_found_r <= lat_nxt;
      out_a_r     <= lat_nxt ? lat_a_nxt : fallback;
      out_b_r     <= lat_nxt ? lat_b_nxt : fallback;
    end
  end

endmodule

`default_nettype wire

>>> src/aost_checker.sv
// ----------------------------------------------------------------------------
// aost_checker
// Port-level checks on the soft-off type scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aml_soft_off_type_scanner_assert.svh"

module aost_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_full,
  input wire logic                        out_empty,
  input wire logic                        out_pop,
  input wire logic                        out_found,
  input wire logic [aost_pkg::TYPE_W-1:0] out_sleep_type_a,
  input wire logic [aost_pkg::TYPE_W-1:0] out_sleep_type_b,
  input wire logic                        cfg_valid,
  input wire logic                        cfg_ready
);

  `AOST_ASSERT_NOW(a_reset_idle, clk, rst_n, $past(!rst_n), out_empty && !in_full, "not idle after reset")
  `AOST_ASSERT_NOW(a_fallback_pair, clk, rst_n, !out_empty && !out_found, out_sleep_type_a == out_sleep_type_b, "fallback result with differing sleep types")
  `AOST_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration transfer refused")
  `AOST_ASSERT_NEXT(a_result_held, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_found) && $stable(out_sleep_type_a) && $stable(out_sleep_type_b), "waiting result changed")

endmodule

bind aml_soft_off_type_scanner aost_checker u_aost_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_found        (out_found),
  .out_sleep_type_a (out_sleep_type_a),
  .out_sleep_type_b (out_sleep_type_b),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Soft-off sleep-type scanner testbench
// Streams table bodies, some holding a soft-off package, some broken or
// truncated and some pure noise, through the byte queue. A behavioural scan
// of each whole body predicts the result at its final byte, and each result
// transfer is compared with the oldest prediction. The run goes through
// phases of sender and receiver idling, fallback settings and one long
// receiver hold-off that fills the block.
// ----------------------------------------------------------------------------

module tb;

  localparam int TYPE_W = aost_pkg::TYPE_W;

  localparam logic [7:0] NAME_OP    = aost_pkg::NAME_OP;
  localparam logic [7:0] PACKAGE_OP = aost_pkg::PACKAGE_OP;
  localparam logic [7:0] CHAR_US    = aost_pkg::CHAR_US;
  localparam logic [7:0] CHAR_S     = aost_pkg::CHAR_S;
  localparam logic [7:0] CHAR_5     = aost_pkg::CHAR_5;
  localparam logic [7:0] OP_ZERO    = aost_pkg::OP_ZERO;
  localparam logic [7:0] OP_ONE     = aost_pkg::OP_ONE;
  localparam logic [7:0] OP_BYTE    = aost_pkg::OP_BYTE;
  localparam logic [7:0] OP_WORD    = aost_pkg::OP_WORD;
  localparam logic [7:0] OP_DWORD   = aost_pkg::OP_DWORD;
  localparam logic [7:0] OP_QWORD   = aost_pkg::OP_QWORD;

  localparam logic [TYPE_W-1:0] FALLBACK_AT_RESET = 7'd5;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 800;
  localparam int QUIET_LIMIT   = 5000;
  localparam int DIR_ROWS_N    = 25;

  typedef struct packed {
    logic              found;
    logic [TYPE_W-1:0] type_a;
    logic [TYPE_W-1:0] type_b;
  } sleep_types_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic         typed;
    sleep_types_t result;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{8'hFF,      1'b1, 1'b1, '{1'b0, 7'd5, 7'd5}},
    '{NAME_OP,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{CHAR_US,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{CHAR_S,     1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{CHAR_5,     1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{CHAR_US,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{PACKAGE_OP, 1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{8'h01,      1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{8'h02,      1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{OP_ZERO,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{OP_ONE,     1'b1, 1'b1, '{1'b1, 7'd0, 7'd1}},
    '{NAME_OP,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{CHAR_US,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{CHAR_S,     1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{CHAR_5,     1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{CHAR_US,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{PACKAGE_OP, 1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{8'h41,      1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{8'h00,      1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{8'h03,      1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{OP_BYTE,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{8'hFF,      1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{OP_WORD,    1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{8'h83,      1'b0, 1'b0, '{1'b0, 7'd0, 7'd0}},
    '{8'h00,      1'b1, 1'b1, '{1'b1, 7'h7F, 7'd3}}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [7:0]        in_data_byte;
  logic              in_last_byte;
  logic              out_empty;
  logic              out_pop;
  logic              out_found;
  logic [TYPE_W-1:0] out_sleep_type_a;
  logic [TYPE_W-1:0] out_sleep_type_b;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TYPE_W-1:0] cfg_fallback_sleep_type;

  logic [7:0]        body_bytes [$];
  logic [7:0]        table_bytes [$];
  sleep_types_t      pending_sleep_types [$];
  logic [TYPE_W-1:0] fallback_type;
  int                send_idle_pct;
  int                recv_stall_pct;
  bit                hold_req;
  int                mismatches;
  int                quiet_cycles;

  aml_soft_off_type_scanner DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_data_byte            (in_data_byte),
    .in_last_byte            (in_last_byte),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_found               (out_found),
    .out_sleep_type_a        (out_sleep_type_a),
    .out_sleep_type_b        (out_sleep_type_b),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_fallback_sleep_type (cfg_fallback_sleep_type)
  );

  always #2 clk = ~clk;

  // Number of value bytes after an integer opcode, or -1 for an opcode that
  // is not an integer.
  function automatic int opcode_tail(logic [7:0] op);
    case (op)
      OP_ZERO, OP_ONE: return 0;
      OP_BYTE:         return 1;
      OP_WORD:         return 2;
      OP_DWORD:        return 4;
      OP_QWORD:        return 8;
      default:         return -1;
    endcase
  endfunction

  function automatic int decode_integer(int at, output logic [TYPE_W-1:0] value);
    int tail;
    value = '0;
    if (at >= body_bytes.size()) return 0;
    tail = opcode_tail(body_bytes[at]);
    if (tail < 0 || at + tail >= body_bytes.size()) return 0;
    value = (tail == 0) ? {6'd0, body_bytes[at][0]} : body_bytes[at + 1][TYPE_W-1:0];
    return tail + 1;
  endfunction

  function automatic bit s5_package_at(int s, output logic [TYPE_W-1:0] type_a,
                                       output logic [TYPE_W-1:0] type_b);
    int pos;
    int used;
    type_a = '0;
    type_b = '0;
    if (body_bytes.size() - s < 7) return 1'b0;
    if (body_bytes[s] != NAME_OP || body_bytes[s + 1] != CHAR_US ||
        body_bytes[s + 2] != CHAR_S || body_bytes[s + 3] != CHAR_5 ||
        body_bytes[s + 4] != CHAR_US || body_bytes[s + 5] != PACKAGE_OP) return 1'b0;
    pos = s + 7 + int'(body_bytes[s + 6][7:6]);
    if (pos >= body_bytes.size()) return 1'b0;
    if (body_bytes[pos] < 8'd2) return 1'b0;
    pos++;
    used = decode_integer(pos, type_a);
    if (used == 0) return 1'b0;
    pos += used;
    used = decode_integer(pos, type_b);
    return used != 0;
  endfunction

  function automatic sleep_types_t predict_sleep_types();
    sleep_types_t r;
    logic [TYPE_W-1:0] a;
    logic [TYPE_W-1:0] b;
    r = '{1'b0, fallback_type, fallback_type};
    for (int s = 0; s < body_bytes.size(); s++) begin
      if (s5_package_at(s, a, b)) begin
        r = '{1'b1, a, b};
        break;
      end
    end
    return r;
  endfunction

  function automatic void note_accepted_byte(logic [7:0] d, logic l, logic typed,
                                             sleep_types_t typed_result);
    sleep_types_t predicted;
    body_bytes.push_back(d);
    if (l) begin
      predicted = predict_sleep_types();
      pending_sleep_types.push_back(typed ? typed_result : predicted);
      body_bytes.delete();
    end
  endfunction

  function automatic logic [7:0] junk_byte();
    case ($urandom_range(11))
      0:       return NAME_OP;
      1:       return PACKAGE_OP;
      2:       return CHAR_US;
      3:       return CHAR_S;
      4:       return CHAR_5;
      5:       return OP_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void append_integer();
    logic [7:0] op;
    int tail;
    case ($urandom_range(6))
      0:       op = OP_ZERO;
      1:       op = OP_ONE;
      2:       op = OP_BYTE;
      3:       op = OP_WORD;
      4:       op = OP_DWORD;
      5:       op = OP_QWORD;
      default: op = 8'($urandom_range(255));
    endcase
    table_bytes.push_back(op);
    tail = opcode_tail(op);
    repeat (tail < 0 ? 0 : tail) table_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void append_package();
    int extra;
    table_bytes.push_back(NAME_OP);
    table_bytes.push_back(CHAR_US);
    table_bytes.push_back(CHAR_S);
    table_bytes.push_back(CHAR_5);
    table_bytes.push_back(CHAR_US);
    table_bytes.push_back(PACKAGE_OP);
    if ($urandom_range(9) == 0)
      table_bytes[table_bytes.size() - 1 - $urandom_range(5)] = 8'($urandom_range(255));
    extra = $urandom_range(3);
    table_bytes.push_back({2'(extra), 6'($urandom_range(63))});
    repeat (extra) table_bytes.push_back(8'($urandom_range(255)));
    table_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(1))
                                                   : 8'($urandom_range(2, 255)));
    append_integer();
    append_integer();
  endfunction

  // Mostly bodies that hold one or two packages after some noise, now and
  // then cut short; the rest is pure noise.
  function automatic void build_table();
    int lead;
    table_bytes.delete();
    lead = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(6);
    repeat (lead) table_bytes.push_back(junk_byte());
    if ($urandom_range(9) < 8) begin
      repeat (($urandom_range(4) == 0) ? 2 : 1) begin
        append_package();
        repeat ($urandom_range(3)) table_bytes.push_back(junk_byte());
      end
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(1, 10)) begin
          if (table_bytes.size() > 1) void'(table_bytes.pop_back());
        end
      end
    end
    if (table_bytes.size() == 0) table_bytes.push_back(junk_byte());
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(logic [7:0] d, logic l, logic typed, sleep_types_t typed_result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push      = 1'b1;
    in_data_byte = d;
    in_last_byte = l;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    note_accepted_byte(d, l, typed, typed_result);
    @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n_bytes);
    int sent;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_bytes) begin
      build_table();
      for (int i = 0; i < table_bytes.size(); i++)
        send_byte(table_bytes[i], i == table_bytes.size() - 1, 1'b0, '0);
      sent += table_bytes.size();
    end
    in_push = 1'b0;
  endtask

  task automatic drain_and_settle();
    while (pending_sleep_types.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fallback(logic [TYPE_W-1:0] value);
    cfg_valid               = 1'b1;
    cfg_fallback_sleep_type = value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    fallback_type = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    rst_n                   = 1'b0;
    in_push                 = 1'b0;
    in_data_byte            = '0;
    in_last_byte            = 1'b0;
    cfg_valid               = 1'b0;
    cfg_fallback_sleep_type = '0;
    fallback_type           = FALLBACK_AT_RESET;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    hold_req                = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS_N; i++)
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].result);
    in_push = 1'b0;

    drain_and_settle();
    write_fallback(7'h7F);
    run_phase(0, 0, 400);

    drain_and_settle();
    write_fallback(7'h00);
    run_phase(83, 0, 400);

    drain_and_settle();
    write_fallback(7'($urandom_range(1, 126)));
    run_phase(0, 83, 400);

    drain_and_settle();
    write_fallback(7'($urandom_range(1, 126)));
    hold_req = 1'b1;
    run_phase(25, 25, 700);

    drain_and_settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // The long hold-off is counted here so that the sender keeps offering
  // bytes until the block fills and raises full.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_pop = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sleep_types_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_sleep_types.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result transfer with none pending: found=%0d a=%0d b=%0d",
                   out_found, out_sleep_type_a, out_sleep_type_b);
      end else begin
        want = pending_sleep_types.pop_front();
        if (out_found !== want.found || out_sleep_type_a !== want.type_a ||
            out_sleep_type_b !== want.type_b) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected found=%0d a=%0d b=%0d, got found=%0d a=%0d b=%0d",
                     want.found, want.type_a, want.type_b,
                     out_found, out_sleep_type_a, out_sleep_type_b);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> aml_soft_off_type_scanner.f
+incdir+src
src/aost_pkg.sv
src/aost_queue.sv
src/aost_front.sv
src/aost_back.sv
src/aml_soft_off_type_scanner.sv
src/aost_checker.sv
tb/sv/tb.sv
